FILE: hw/rtl/srw_pkg.sv
// Shared types, register codes and helpers for the sub-block row address walker.
// No dependencies; every other file in hw/rtl imports this package.
package srw_pkg;

  localparam int unsigned MAX_DIMS = 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DIM_COUNT      = 3'd0,
    REG_ELEMENT_BYTES  = 3'd1,
    REG_ARRAY_SIZE_X   = 3'd2,
    REG_ARRAY_SIZE_Y   = 3'd3,
    REG_ARRAY_ORIGIN_X = 3'd4,
    REG_ARRAY_ORIGIN_Y = 3'd5,
    REG_ARRAY_ORIGIN_Z = 3'd6
  } cfg_reg_t;

  // Input item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic        copy_in;
    logic [15:0] area_start_x;
    logic [15:0] area_start_y;
    logic [15:0] area_start_z;
    logic [15:0] area_end_x;
    logic [15:0] area_end_y;
    logic [15:0] area_end_z;
  } in_item_t;

  typedef struct packed {
    logic [31:0] array_byte_offset;
    logic [31:0] buffer_byte_offset;
    logic [21:0] row_bytes;
    logic        direction_in;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  dim_count;
    logic [6:0]  element_bytes;
    logic [15:0] array_size_x;
    logic [15:0] array_size_y;
    logic [15:0] array_origin_x;
    logic [15:0] array_origin_y;
    logic [15:0] array_origin_z;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;    // latch a new area and its row size
    logic advance;  // step to the next row
    logic mul;      // row products, last mark
    logic sum1;     // x plus y term, z product
    logic sum2;     // add z term
    logic scale;    // scale element index to bytes
  } dp_cmd_t;

  typedef struct packed {
    logic walk_active;
  } dp_status_t;

  function automatic logic [1:0] dims_in_use(logic [1:0] dc);
    logic [1:0] d;
    d = dc;
    if (d == 2'd0) d = 2'd1;
    if (32'(d) > MAX_DIMS) d = 2'(MAX_DIMS);
    return d;
  endfunction

endpackage

FILE: hw/rtl/srw_cfg_regs.sv
// Configuration register file of the row address walker.
// Depends on srw_pkg for the register codes and the cfg_t struct.
module srw_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output srw_pkg::cfg_t cfg
);
  import srw_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIM_COUNT:      cfg_nxt.dim_count      = cfg_wdata[1:0];
        REG_ELEMENT_BYTES:  cfg_nxt.element_bytes  = cfg_wdata[6:0];
        REG_ARRAY_SIZE_X:   cfg_nxt.array_size_x   = cfg_wdata;
        REG_ARRAY_SIZE_Y:   cfg_nxt.array_size_y   = cfg_wdata;
        REG_ARRAY_ORIGIN_X: cfg_nxt.array_origin_x = cfg_wdata;
        REG_ARRAY_ORIGIN_Y: cfg_nxt.array_origin_y = cfg_wdata;
        REG_ARRAY_ORIGIN_Z: cfg_nxt.array_origin_z = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{dim_count: 2'd1, element_bytes: 7'd1, array_size_x: 16'd1,
                 array_size_y: 16'd1, array_origin_x: 16'd0,
                 array_origin_y: 16'd0, array_origin_z: 16'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/srw_datapath.sv
// Datapath of the row address walker: area bounds, row counters and the
// multi-cycle offset arithmetic. Depends on srw_pkg; driven by srw_ctrl.
module srw_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  srw_pkg::cfg_t       cfg,
  input  srw_pkg::in_item_t   in_data,
  input  srw_pkg::dp_cmd_t    cmd,
  output srw_pkg::dp_status_t status,
  output srw_pkg::out_item_t  out_data
);
  import srw_pkg::*;

  logic [15:0] lx_r, ybeg_r, yend_r, zend_r, y_r, z_r;
  logic [15:0] lx_nxt, ybeg_nxt, yend_nxt, zend_nxt, y_nxt, z_nxt;
  logic        dir_r, dir_nxt, last_r, last_nxt;
  logic        active_r, active_nxt;
  logic [31:0] buf_r, buf_nxt, arr_r, arr_nxt;
  logic [21:0] rowb_r, rowb_nxt;
  logic [31:0] prod_y_r, prod_y_nxt, sxsy_r, sxsy_nxt, prod_z_r, prod_z_nxt;
  logic [31:0] sum_r, sum_nxt, idx_r, idx_nxt;

  logic [1:0]  dims;
  logic [15:0] y_inc, z_inc, ext_in;
  logic [22:0] rowb_full;
  logic [47:0] prod_z_full;
  logic [38:0] scaled_full;
  logic        last_calc;

  always_comb begin
    dims        = dims_in_use(cfg.dim_count);
    y_inc       = y_r + 16'd1;
    z_inc       = z_r + 16'd1;
    ext_in      = in_data.area_end_x - in_data.area_start_x;
    rowb_full   = 23'(cfg.element_bytes) * 23'(ext_in);
    prod_z_full = 48'(z_r) * 48'(sxsy_r);
    scaled_full = 39'(idx_r) * 39'(cfg.element_bytes);
    last_calc   = (dims < 2'd2) ||
                  ((y_inc == yend_r) && ((dims < 2'd3) || (z_inc == zend_r)));
  end

  always_comb begin
    lx_nxt     = lx_r;
    ybeg_nxt   = ybeg_r;
    yend_nxt   = yend_r;
    zend_nxt   = zend_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    dir_nxt    = dir_r;
    buf_nxt    = buf_r;
    rowb_nxt   = rowb_r;
    last_nxt   = last_r;
    active_nxt = active_r;
    prod_y_nxt = prod_y_r;
    sxsy_nxt   = sxsy_r;
    prod_z_nxt = prod_z_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    arr_nxt    = arr_r;

    if (cmd.start) begin
      // translate global area to local coordinates; row size holds for the walk
      lx_nxt   = in_data.area_start_x - cfg.array_origin_x;
      ybeg_nxt = in_data.area_start_y - cfg.array_origin_y;
      yend_nxt = in_data.area_end_y - cfg.array_origin_y;
      zend_nxt = in_data.area_end_z - cfg.array_origin_z;
      y_nxt    = in_data.area_start_y - cfg.array_origin_y;
      z_nxt    = in_data.area_start_z - cfg.array_origin_z;
      dir_nxt  = in_data.copy_in;
      rowb_nxt = rowb_full[21:0];
      buf_nxt  = '0;
    end
    if (cmd.advance) begin
      // y steps first; on reaching its end it wraps and z advances
      if (y_inc == yend_r) begin
        y_nxt = ybeg_r;
        z_nxt = z_inc;
      end else begin
        y_nxt = y_inc;
      end
      buf_nxt = buf_r + 32'(rowb_r);
    end
    if (cmd.mul) begin
      prod_y_nxt = 32'(y_r) * 32'(cfg.array_size_x);
      sxsy_nxt   = 32'(cfg.array_size_x) * 32'(cfg.array_size_y);
      last_nxt   = last_calc;
      active_nxt = !last_calc;
    end
    if (cmd.sum1) begin
      sum_nxt    = 32'(lx_r) + ((dims >= 2'd2) ? prod_y_r : 32'd0);
      prod_z_nxt = prod_z_full[31:0];
    end
    if (cmd.sum2) begin
      idx_nxt = sum_r + ((dims >= 2'd3) ? prod_z_r : 32'd0);
    end
    if (cmd.scale) begin
      arr_nxt = scaled_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lx_r     <= lx_nxt;
    ybeg_r   <= ybeg_nxt;
    yend_r   <= yend_nxt;
    zend_r   <= zend_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    dir_r    <= dir_nxt;
    buf_r    <= buf_nxt;
    rowb_r   <= rowb_nxt;
    last_r   <= last_nxt;
    prod_y_r <= prod_y_nxt;
    sxsy_r   <= sxsy_nxt;
    prod_z_r <= prod_z_nxt;
    sum_r    <= sum_nxt;
    idx_r    <= idx_nxt;
    arr_r    <= arr_nxt;
  end

  assign status.walk_active = active_r;

  assign out_data = '{array_byte_offset: arr_r, buffer_byte_offset: buf_r,
                      row_bytes: rowb_r, direction_in: dir_r, last_row: last_r};

endmodule

FILE: hw/rtl/srw_ctrl.sv
// Controller of the row address walker: accepts items and sequences the
// datapath through its arithmetic steps. Depends on srw_pkg.
module srw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  output logic                out_valid,
  input  logic                out_ready,
  input  srw_pkg::dp_status_t status,
  output srw_pkg::dp_cmd_t    cmd
);
  import srw_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_SUM1  = 6'b000100,
    ST_SUM2  = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_START) begin
            cmd.start = 1'b1;
            state_nxt = ST_MUL;
          end else if (status.walk_active) begin
            cmd.advance = 1'b1;
            state_nxt   = ST_MUL;
          end
          // next without an active walk: drop it
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM1;
      end
      ST_SUM1: begin
        cmd.sum1  = 1'b1;
        state_nxt = ST_SUM2;
      end
      ST_SUM2: begin
        cmd.sum2  = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/subblock_row_address_walker_top.sv
// Top level of the sub-block row address walker: configuration registers,
// controller and datapath. Depends on srw_pkg, srw_cfg_regs, srw_ctrl, srw_datapath.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+-----------------------------
//   input    | in_valid, in_ready, in_data    | start or next-row item
//   result   | out_valid, out_ready, out_data | one row descriptor
//   config   | cfg_wr_en, cfg_index, cfg_wdata| register write, no wait
//
// One item at a time. A start item or a next item of an active walk gives
// its row after acceptance (multiply, two adds, byte scaling, then the
// output register). A next item with no active walk is taken and dropped.
// Reset is synchronous and leaves no walk active; a stalled result holds
// until taken.
module subblock_row_address_walker_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srw_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import srw_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  srw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  srw_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

FILE: hw/rtl/srw_checker.sv
// Port-level checks for the row address walker, bound to the top level.
// Depends on srw_pkg and subblock_row_address_walker_top.
module srw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input srw_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input srw_pkg::out_item_t out_data
);
  import srw_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no item is taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("item taken while result pending");

  // a start item gives its first row
  a_start_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == MODE_START |-> ##5 out_valid)
    else $error("start item gave no row");

  // the first row of a walk sits at the buffer start
  a_start_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == MODE_START
      |-> ##5 out_data.buffer_byte_offset == 32'd0)
    else $error("first row not at buffer start");

endmodule

bind subblock_row_address_walker_top srw_checker u_srw_checker (.*);

FILE: test/subblock_row_address_walker_top_test.sv
// Self-checking bench for the sub-block row address walker: directed corner walks, then
// random area walks under changing register settings with random stalls on both channels.
// Depends on srw_pkg and subblock_row_address_walker_top.
module subblock_row_address_walker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srw_pkg::*;

  localparam int unsigned TOTAL_ITEMS   = 1650;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Row predictor and store of expected row descriptors
  class row_walk_scoreboard;
    cfg_t        regs;
    bit          walking;
    logic [15:0] x_local, y_first, y_stop, z_stop, cur_y, cur_z;
    logic [21:0] row_stride;
    logic [31:0] buf_off;
    logic        dir;
    out_item_t   pending_rows[$];
    int unsigned items_seen, rows_predicted, rows_checked, errors;

    function new();
      regs = '0;
      regs.dim_count = 2'd1;
      regs.element_bytes = 7'd1;
      regs.array_size_x = 16'd1;
      regs.array_size_y = 16'd1;
      walking = 1'b0;
      {x_local, y_first, y_stop, z_stop, cur_y, cur_z} = '0;
      row_stride = '0;
      buf_off = '0;
      dir = 1'b0;
      items_seen = 0;
      rows_predicted = 0;
      rows_checked = 0;
      errors = 0;
    endfunction

    function void apply_reg_write(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        REG_DIM_COUNT:      regs.dim_count = v[1:0];
        REG_ELEMENT_BYTES:  regs.element_bytes = v[6:0];
        REG_ARRAY_SIZE_X:   regs.array_size_x = v;
        REG_ARRAY_SIZE_Y:   regs.array_size_y = v;
        REG_ARRAY_ORIGIN_X: regs.array_origin_x = v;
        REG_ARRAY_ORIGIN_Y: regs.array_origin_y = v;
        REG_ARRAY_ORIGIN_Z: regs.array_origin_z = v;
        default: ;
      endcase
    endfunction

    function void accept_item(in_item_t it);
      int unsigned dims;
      logic [15:0] ext, y_next, z_next;
      logic [31:0] bytes;
      logic [63:0] elem, plane;
      out_item_t   row;
      items_seen++;
      dims = (regs.dim_count == 2'd0) ? 1 : int'(regs.dim_count);
      if (dims > MAX_DIMS) dims = MAX_DIMS;
      if (it.mode == MODE_START) begin
        // translate the area from global to local coordinates
        x_local = it.area_start_x - regs.array_origin_x;
        y_first = it.area_start_y - regs.array_origin_y;
        y_stop = it.area_end_y - regs.array_origin_y;
        z_stop = it.area_end_z - regs.array_origin_z;
        cur_y = y_first;
        cur_z = it.area_start_z - regs.array_origin_z;
        ext = it.area_end_x - it.area_start_x;
        bytes = 32'(regs.element_bytes) * 32'(ext);
        row_stride = bytes[21:0];
        dir = it.copy_in;
        buf_off = '0;
      end else begin
        if (!walking) return;
        cur_y = cur_y + 16'd1;
        if (cur_y == y_stop) begin
          cur_y = y_first;
          cur_z = cur_z + 16'd1;
        end
        buf_off = buf_off + 32'(row_stride);
      end
      elem = 64'(x_local);
      if (dims >= 2) elem += 64'(cur_y) * 64'(regs.array_size_x);
      if (dims >= 3) begin
        plane = (64'(regs.array_size_x) * 64'(regs.array_size_y)) & 64'hFFFF_FFFF;
        elem += 64'(cur_z) * plane;
      end
      elem &= 64'hFFFF_FFFF;
      elem = elem * 64'(regs.element_bytes);
      y_next = cur_y + 16'd1;
      z_next = cur_z + 16'd1;
      row.array_byte_offset = elem[31:0];
      row.buffer_byte_offset = buf_off;
      row.row_bytes = row_stride;
      row.direction_in = dir;
      row.last_row = (dims < 2) || (y_next == y_stop && (dims < 3 || z_next == z_stop));
      walking = !row.last_row;
      pending_rows = {pending_rows, row};
      rows_predicted++;
    endfunction

    function void check_row(out_item_t got);
      out_item_t want;
      if (pending_rows.size() == 0) begin
        note_error("row with none expected", '0, got);
        return;
      end
      want = pending_rows.pop_front();
      rows_checked++;
      if (got.array_byte_offset !== want.array_byte_offset ||
          got.buffer_byte_offset !== want.buffer_byte_offset ||
          got.row_bytes !== want.row_bytes ||
          got.direction_in !== want.direction_in ||
          got.last_row !== want.last_row)
        note_error("row mismatch", want, got);
    endfunction

    function void note_error(string what, out_item_t want, out_item_t got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("[%0t] %s: expected %s, got %s", $time, what, row_text(want), row_text(got));
    endfunction

    function string row_text(out_item_t r);
      return $sformatf("{array %h buffer %h bytes %0d dir %b last %b}", r.array_byte_offset,
                       r.buffer_byte_offset, r.row_bytes, r.direction_in, r.last_row);
    endfunction

    function int unsigned outstanding();
      return pending_rows.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  row_walk_scoreboard sb = new();
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned settings_written = 0;

  subblock_row_address_walker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= !sink_idle_on || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d rows outstanding", cycle_count,
               sb.outstanding());
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) sb.apply_reg_write(cfg_reg_t'(cfg_index), cfg_wdata);
      if (in_valid && in_ready) sb.accept_item(in_data);
      if (out_valid && out_ready) sb.check_row(out_data);
    end
  end

  function automatic in_item_t random_item(logic mode);
    logic [127:0] r;
    in_item_t     it;
    r = {$urandom, $urandom, $urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    it.mode = mode;
    return it;
  endfunction

  function automatic in_item_t start_item(logic copy, logic [15:0] sx, logic [15:0] sy,
                                          logic [15:0] sz, logic [15:0] ex, logic [15:0] ey,
                                          logic [15:0] ez);
    in_item_t it;
    it.mode = MODE_START;
    it.copy_in = copy;
    it.area_start_x = sx;
    it.area_start_y = sy;
    it.area_start_z = sz;
    it.area_end_x = ex;
    it.area_end_y = ey;
    it.area_end_z = ez;
    return it;
  endfunction

  function automatic logic [15:0] random_extent();
    case ($urandom_range(7))
      0:       return 16'hFFFF;
      1:       return 16'd1;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1024, 1));
    endcase
  endfunction

  function automatic logic [15:0] random_origin();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t        c;
    int unsigned pick;
    pick = $urandom_range(19);
    c.dim_count = (pick == 0) ? 2'd0 : (pick < 4) ? 2'd1 : (pick < 11) ? 2'd2 : 2'd3;
    case ($urandom_range(7))
      0:       c.element_bytes = 7'd64;
      1:       c.element_bytes = 7'd1;
      2:       c.element_bytes = 7'($urandom);
      default: c.element_bytes = 7'($urandom_range(64, 1));
    endcase
    c.array_size_x = random_extent();
    c.array_size_y = random_extent();
    c.array_origin_x = random_origin();
    c.array_origin_y = random_origin();
    c.array_origin_z = random_origin();
    return c;
  endfunction

  // Write every register in index order; narrow ones sometimes carry junk above their width
  task automatic write_regs(input cfg_t c);
    cfg_reg_t    r;
    logic [15:0] v;
    r = REG_DIM_COUNT;
    do begin
      case (r)
        REG_DIM_COUNT: begin
          v = 16'(c.dim_count);
          if ($urandom_range(3) == 0) v[15:2] = 14'($urandom);
        end
        REG_ELEMENT_BYTES: begin
          v = 16'(c.element_bytes);
          if ($urandom_range(3) == 0) v[15:7] = 9'($urandom);
        end
        REG_ARRAY_SIZE_X:   v = c.array_size_x;
        REG_ARRAY_SIZE_Y:   v = c.array_size_y;
        REG_ARRAY_ORIGIN_X: v = c.array_origin_x;
        REG_ARRAY_ORIGIN_Y: v = c.array_origin_y;
        default:            v = c.array_origin_z;
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= v;
      @(posedge clk);
      r = r.next();
    end while (r != REG_DIM_COUNT);
    cfg_wr_en <= 1'b0;
    settings_written++;
  endtask

  task automatic send_item(input in_item_t it);
    if (src_idle_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected row, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_walk();
    int unsigned dims, ny, nz, rows, steps;
    logic [15:0] ext;
    in_item_t    it;
    dims = (sb.regs.dim_count == 2'd0) ? 1 : int'(sb.regs.dim_count);
    ny = $urandom_range(6, 1);
    nz = (dims == 3) ? $urandom_range(4, 1) : 1;
    rows = (dims == 1) ? 1 : ny * nz;
    case ($urandom_range(9))
      0:       ext = 16'h0000;
      1:       ext = 16'hFFFF;
      default: ext = 16'($urandom_range(64, 1));
    endcase
    it = random_item(MODE_START);
    it.area_end_x = it.area_start_x + ext;
    if (dims >= 2) it.area_end_y = it.area_start_y + 16'(ny);
    if (dims == 3) it.area_end_z = it.area_start_z + 16'(nz);
    send_item(it);
    steps = rows - 1;
    // abandon some walks early, overrun the end of others
    if ($urandom_range(9) == 0) steps = $urandom_range(steps);
    else if ($urandom_range(4) == 0) steps += $urandom_range(2, 1);
    repeat (steps) send_item(random_item(MODE_NEXT));
  endtask

  task automatic directed_walks();
    cfg_t c;
    // reset settings: one dimension, one-byte elements, origin at zero
    send_item(random_item(MODE_NEXT));
    send_item(start_item(1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_item(start_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(start_item(1'b1, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0));
    send_item(random_item(MODE_NEXT));
    drain();

    c = '{dim_count: 2'd2, element_bytes: 7'd64, array_size_x: 16'hFFFF,
          array_size_y: 16'hFFFF, array_origin_x: 16'hFFFF, array_origin_y: 16'hFFFF,
          array_origin_z: 16'hFFFF};
    write_regs(c);
    // widest row, three rows, then one next past the end
    send_item(start_item(1'b0, 16'h0, 16'd5, 16'($urandom), 16'hFFFF, 16'd8, 16'($urandom)));
    repeat (3) send_item(random_item(MODE_NEXT));
    // reversed y range, then an empty one, each cut short by a fresh start
    send_item(start_item(1'b1, 16'd3, 16'd10, 16'h0, 16'd9, 16'd7, 16'h0));
    send_item(random_item(MODE_NEXT));
    send_item(start_item(1'b0, 16'd7, 16'd20, 16'h0, 16'd8, 16'd20, 16'h0));
    send_item(random_item(MODE_NEXT));
    send_item(start_item(1'b1, 16'd1, 16'd0, 16'h0, 16'd2, 16'd1, 16'h0));
    drain();

    c = '{dim_count: 2'd3, element_bytes: 7'd127, array_size_x: 16'hFFFF,
          array_size_y: 16'hFFFF, array_origin_x: 16'h0, array_origin_y: 16'h0,
          array_origin_z: 16'h0};
    write_regs(c);
    // reversed x extent and a z range that wraps through zero: four rows
    send_item(start_item(1'b0, 16'd100, 16'd3, 16'hFFFE, 16'd50, 16'd5, 16'h0));
    repeat (4) send_item(random_item(MODE_NEXT));
    drain();

    c = '{dim_count: 2'd0, element_bytes: 7'd0, array_size_x: 16'd1000,
          array_size_y: 16'd1000, array_origin_x: 16'd1, array_origin_y: 16'd1,
          array_origin_z: 16'd1};
    write_regs(c);
    send_item(random_item(MODE_START));
    send_item(random_item(MODE_NEXT));
    drain();
  endtask

  initial begin
    int unsigned phase_base, phase;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_walks();

    phase = 0;
    while (sb.items_seen < TOTAL_ITEMS) begin
      // one phase runs with no idling on either side
      src_idle_on = (phase != 3);
      sink_idle_on <= (phase != 3);
      write_regs(random_cfg());
      phase_base = sb.items_seen;
      while (sb.items_seen - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(99) < 12)
          send_item(random_item($urandom_range(1) ? MODE_NEXT : MODE_START));
        else
          random_walk();
      end
      drain();
      phase++;
    end

    $display("Covered %0d items and %0d row descriptors over %0d register settings,",
             sb.items_seen, sb.rows_checked, settings_written);
    $display("one to three dimensions, reversed and empty ranges, abandoned walks: %0d errors",
             sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/srw_pkg.sv
hw/rtl/srw_cfg_regs.sv
hw/rtl/srw_datapath.sv
hw/rtl/srw_ctrl.sv
hw/rtl/subblock_row_address_walker_top.sv
hw/rtl/srw_checker.sv
test/subblock_row_address_walker_top_test.sv
